/* rtl/assert_macros.svh */
// Assertion macros shared by the value noise RTL.
// Depends on nothing; define NO_ASSERTIONS to drop all checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AST_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define AST_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`else
`define AST_IMPL(lbl, clk, rst_n, a, c)
`define AST_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

/* rtl/ovn_pkg.sv */
// Package for the octave value noise unit: widths and sequencer codes.
// Depends on nothing.
`default_nettype none
package ovn_pkg;
	localparam int SEED_W = 16;
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;
endpackage
`default_nettype wire

/* rtl/ovn_ram.sv */
// Generic single port RAM with registered read.
// Depends on nothing.
`default_nettype none
module ovn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

/* rtl/ovn_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on nothing.
`default_nettype none
module ovn_div #(
	parameter int NW = 48,
	parameter int DW = 27
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          go,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic      [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff = trial - {1'b0, den_q};
	assign quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DW]) begin
				rem_q <= diff[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/octave_value_noise_2d_unit.sv */
// Top level of the 2D octave value noise unit: sequencer, seed RAM, shared MAC.
// Depends on ovn_pkg, ovn_ram, ovn_div, assert_macros.svh.
// Load: written straight into the seed RAM while idle; busy stays low. Query: busy
// through each octave's MAC steps (RD, C0..C3, ACC) and its bit-serial scale divide,
// then through the final divide; the strobe is registered from the divider's done.
// busy is high from acceptance until the strobe; results cannot be stalled.
// Reset clears control and config registers to their reset values.
`default_nettype none
`include "assert_macros.svh"
module octave_value_noise_2d_unit
	import ovn_pkg::*;
#(
	parameter int SIDE_LOG2 = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire logic         op,
	input  wire logic [15:0]  seed_index,
	input  wire logic [15:0]  seed_value,
	input  wire logic [7:0]   pos_x,
	input  wire logic [7:0]   pos_y,
	output logic              noise_valid,
	output logic [15:0]       noise,
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [12:0]  cfg_data
);
	localparam int AW = 2 * SIDE_LOG2;
	localparam int SL = SIDE_LOG2;
	localparam int SCALE_W = 25 + 2 * SIDE_LOG2;
	localparam int ACCS_W = SCALE_W + 1;
	localparam int ACCN_W = ACCS_W + SEED_W;
	localparam int DW = ACCS_W;
	localparam int NW = ACCN_W;
	localparam int OW = $clog2(SIDE_LOG2 + 2);
	localparam int PW = SIDE_LOG2 + 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;
	localparam logic [3:0] ST_C0   = 4'd2;
	localparam logic [3:0] ST_C1   = 4'd3;
	localparam logic [3:0] ST_C2   = 4'd4;
	localparam logic [3:0] ST_C3   = 4'd5;
	localparam logic [3:0] ST_ACC  = 4'd6;
	localparam logic [3:0] ST_SDIV = 4'd7;
	localparam logic [3:0] ST_SWT  = 4'd8;
	localparam logic [3:0] ST_NDIV = 4'd9;
	localparam logic [3:0] ST_NWT  = 4'd10;

	logic [3:0]        state_q;
	logic [3:0]        octc_q;
	logic [12:0]       bias_q;
	logic [SL-1:0]     x_q, y_q;
	logic [OW-1:0]     oct_q, nocts_q;
	logic [1:0]        corner_q;
	logic [SEED_W-1:0] rdata;
	logic [AW-1:0]     raddr;
	logic [SCALE_W-1:0] scale_q;
	logic [ACCS_W-1:0] accs_q;
	logic [ACCN_W-1:0] accn_q;
	logic [2*SL+SEED_W-1:0] v_q;
	logic [SEED_W+SL-1:0]   top_q;
	logic [SEED_W+SL-1:0]   row_q;
	logic [SL-1:0]     shv;
	logic [PW-1:0]     pitch, dxw, dyw, wx, wy;
	logic [SL-1:0]     x1, y1, x2, y2;
	logic              div_go, div_done;
	logic [NW-1:0]     div_num, div_quo;
	logic [DW-1:0]     div_den;
	logic [12:0]       bsat;
	logic [3:0]        nsat;
	logic [SEED_W+PW-1:0] mprod;
	logic [SEED_W+SL-1:0] mop_a;
	logic [PW-1:0]        mop_b;
	logic [SEED_W+SL+PW-1:0] mul;
	logic [SEED_W-1:0]  sample;
	logic [2*SL+SEED_W-1:0] v_next;

	assign shv = SL'(SL) - SL'(oct_q);
	assign pitch = PW'(1) << shv;
	assign dxw = PW'(x_q) & (pitch - PW'(1));
	assign dyw = PW'(y_q) & (pitch - PW'(1));
	assign x1 = x_q - SL'(dxw);
	assign y1 = y_q - SL'(dyw);
	assign x2 = x1 + SL'(pitch);
	assign y2 = y1 + SL'(pitch);
	assign wx = corner_q[0] ? pitch - dxw : dxw;
	assign wy = corner_q[1] ? dyw : pitch - dyw;

	always_comb begin
		case (corner_q)
			2'd0: raddr = {y1, x1};
			2'd1: raddr = {y1, x2};
			2'd2: raddr = {y2, x1};
			default: raddr = {y2, x2};
		endcase
	end

	// shared multiplier: seed * x weight, then row sum * y weight
	assign mop_a = (state_q == ST_ACC) ? top_q : (SEED_W + SL)'(rdata);
	assign mop_b = (state_q == ST_ACC) ? wy : wx;
	assign mul = mop_a * mop_b;
	assign mprod = mul[SEED_W+PW-1:0];
	assign v_next = (2*SL+SEED_W)'(v_q);
	assign sample = SEED_W'(v_q >> (2 * shv));

	assign bsat = (bias_q < 13'd64) ? 13'd64 : ((bias_q > 13'd4096) ? 13'd4096 : bias_q);
	assign nsat = (octc_q == 4'd0) ? 4'd1 :
		((octc_q > 4'(SL + 1)) ? 4'(SL + 1) : octc_q);

	assign div_go = (state_q == ST_SDIV) || (state_q == ST_NDIV);
	assign div_num = (state_q == ST_SDIV) ? NW'({scale_q, 8'd0}) : NW'(accn_q);
	assign div_den = (state_q == ST_SDIV) ? DW'(bsat) : accs_q;

	ovn_ram #(.WIDTH(SEED_W), .DEPTH(1 << AW)) u_ram (
		.clk(clk),
		.we(start && !busy && op == OP_LOAD),
		.addr(state_q == ST_IDLE ? AW'(seed_index) : raddr),
		.wdata(seed_value),
		.rdata(rdata)
	);

	ovn_div #(.NW(NW), .DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go),
		.num(div_num), .den(div_den), .done(div_done), .quo(div_quo)
	);

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			octc_q <= 4'd8;
			bias_q <= 13'd512;
			noise_valid <= 1'b0;
		end else begin
			noise_valid <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == 1'b0) octc_q <= cfg_data[3:0];
				else bias_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: if (start && op == OP_QUERY) state_q <= ST_RD;
				ST_RD: state_q <= ST_C0;
				ST_C0: state_q <= ST_C1;
				ST_C1: state_q <= ST_C2;
				ST_C2: state_q <= ST_C3;
				ST_C3: state_q <= ST_ACC;
				ST_ACC: state_q <= ST_SDIV;
				ST_SDIV: state_q <= ST_SWT;
				ST_SWT: if (div_done) begin
					state_q <= (oct_q + OW'(1) == nocts_q) ? ST_NDIV : ST_RD;
				end
				ST_NDIV: state_q <= ST_NWT;
				ST_NWT: if (div_done) begin
					state_q <= ST_IDLE;
					noise_valid <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// corner order: RD issues corner 0; C0..C3 consume corners 0..3
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q <= SL'(pos_x);
				y_q <= SL'(pos_y);
				oct_q <= '0;
				nocts_q <= OW'(nsat);
				corner_q <= 2'd0;
				scale_q <= SCALE_W'(1) << 24;
				accs_q <= '0;
				accn_q <= '0;
			end
			ST_RD: corner_q <= 2'd1;
			ST_C0: begin
				row_q <= (SEED_W + SL)'(mprod);
				corner_q <= 2'd2;
			end
			ST_C1: begin
				top_q <= row_q + (SEED_W + SL)'(mprod);
				corner_q <= 2'd3;
			end
			ST_C2: begin
				row_q <= (SEED_W + SL)'(mprod);
				corner_q <= 2'd0;
			end
			ST_C3: begin
				v_q <= (2*SL+SEED_W)'(top_q) * (2*SL+SEED_W)'(wy);
				top_q <= row_q + (SEED_W + SL)'(mprod);
				corner_q <= 2'd2;
			end
			ST_ACC: begin
				v_q <= v_next + (2*SL+SEED_W)'(mul);
			end
			ST_SDIV: begin
				accs_q <= accs_q + ACCS_W'(scale_q);
				accn_q <= accn_q + ACCN_W'(sample) * ACCN_W'(scale_q);
			end
			ST_SWT: if (div_done) begin
				scale_q <= SCALE_W'(div_quo);
				oct_q <= oct_q + OW'(1);
				corner_q <= 2'd0;
			end
			ST_NWT: if (div_done) noise <= (div_quo > NW'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];
			default: ;
		endcase
	end

	`AST_NEXT(a_strobe_one, clk, arst_n, noise_valid, !noise_valid)
	`AST_IMPL(a_strobe_busy, clk, arst_n, noise_valid, !busy)
	`AST_IMPL(a_oct_bound, clk, arst_n, busy, oct_q <= nocts_q)
	`AST_NEXT(a_load_idle, clk, arst_n, start && !busy && op == OP_LOAD, !busy)
endmodule
`default_nettype wire
